[hw/rtl/rse_pkg.sv]
// Package for the RPN stack evaluator: widths, status codes, token characters,
// microcode control word types and the microcode program.
// No dependencies; used by rse_div, rse_seq and rpn_stack_evaluator.
package rse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int TOK_W           = 8;
    localparam int ST_W            = 3;
    localparam int UPC_W           = 5;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_ILLEGAL = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDER   = 3'd2;
    localparam logic [ST_W-1:0] ST_OVER    = 3'd3;
    localparam logic [ST_W-1:0] ST_DIVZERO = 3'd4;
    localparam logic [ST_W-1:0] ST_IGNORED = 3'd5;

    localparam logic [TOK_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [TOK_W-1:0] CH_NINE  = 8'h39;
    localparam logic [TOK_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [TOK_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [TOK_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [TOK_W-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOREQ,
        C_FINISH,
        C_ABORT,
        C_DIGIT,
        C_ARITH,
        C_DIV,
        C_DIVBUSY,
        C_OUTFREE
    } cond_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_ILLEGAL,
        A_FINISH,
        A_IGNORE,
        A_DIGIT,
        A_POP,
        A_LOAD,
        A_ALU,
        A_PUSH,
        A_EMIT,
        A_DIVGO,
        A_DIVTAKE
    } act_t;

    typedef struct packed {
        cond_t            cond;
        logic [UPC_W-1:0] target;
        act_t             act;
    } ctl_t;

    typedef struct packed {
        logic noreq;
        logic finish;
        logic aborted;
        logic digit;
        logic arith;
        logic div;
        logic div_busy;
        logic out_free;
    } flags_t;

    localparam logic [UPC_W-1:0] U_WAIT = 5'd0;
    localparam logic [UPC_W-1:0] U_ILL  = 5'd5;
    localparam logic [UPC_W-1:0] U_FIN  = 5'd6;
    localparam logic [UPC_W-1:0] U_IGN  = 5'd7;
    localparam logic [UPC_W-1:0] U_DIG  = 5'd8;
    localparam logic [UPC_W-1:0] U_OPR  = 5'd9;
    localparam logic [UPC_W-1:0] U_PSH  = 5'd12;
    localparam logic [UPC_W-1:0] U_EMIT = 5'd13;
    localparam logic [UPC_W-1:0] U_DGO  = 5'd15;
    localparam logic [UPC_W-1:0] U_DWT  = 5'd16;

    function automatic ctl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctl_t w;
        unique case (addr)
            5'd0:    w = '{cond: C_NOREQ,   target: U_WAIT, act: A_ACCEPT};
            5'd1:    w = '{cond: C_FINISH,  target: U_FIN,  act: A_NONE};
            5'd2:    w = '{cond: C_ABORT,   target: U_IGN,  act: A_NONE};
            5'd3:    w = '{cond: C_DIGIT,   target: U_DIG,  act: A_NONE};
            5'd4:    w = '{cond: C_ARITH,   target: U_OPR,  act: A_NONE};
            5'd5:    w = '{cond: C_ALWAYS,  target: U_EMIT, act: A_ILLEGAL};
            5'd6:    w = '{cond: C_ALWAYS,  target: U_EMIT, act: A_FINISH};
            5'd7:    w = '{cond: C_ALWAYS,  target: U_EMIT, act: A_IGNORE};
            5'd8:    w = '{cond: C_ALWAYS,  target: U_EMIT, act: A_DIGIT};
            5'd9:    w = '{cond: C_NEVER,   target: U_WAIT, act: A_POP};
            5'd10:   w = '{cond: C_DIV,     target: U_DGO,  act: A_LOAD};
            5'd11:   w = '{cond: C_NEVER,   target: U_WAIT, act: A_ALU};
            5'd12:   w = '{cond: C_NEVER,   target: U_WAIT, act: A_PUSH};
            5'd13:   w = '{cond: C_OUTFREE, target: U_WAIT, act: A_EMIT};
            5'd14:   w = '{cond: C_ALWAYS,  target: U_EMIT, act: A_NONE};
            5'd15:   w = '{cond: C_NEVER,   target: U_WAIT, act: A_DIVGO};
            5'd16:   w = '{cond: C_DIVBUSY, target: U_DWT,  act: A_NONE};
            5'd17:   w = '{cond: C_ALWAYS,  target: U_PSH,  act: A_DIVTAKE};
            default: w = '{cond: C_ALWAYS,  target: U_WAIT, act: A_NONE};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/rse_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the operand stack.
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rse_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rse_pkg for the data width.
module rse_div
    import rse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] mb_reg, mb_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, mb_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        mb_next  = mb_reg;
        neg_next = neg_reg;
        if (start)
        begin
            neg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            quo_next = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            mb_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_next = '0;
            cnt_next = CNT_W'(DATA_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

[hw/rtl/rse_seq.sv]
// Microcode sequencer: step counter, program table lookup, conditional jumps.
// Depends on rse_pkg for the control word, flags and program.
module rse_seq
    import rse_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctl_t   ctl
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             take;

    assign ctl = ucode_rom(upc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            C_NEVER:   take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_NOREQ:   take = flags.noreq;
            C_FINISH:  take = flags.finish;
            C_ABORT:   take = flags.aborted;
            C_DIGIT:   take = flags.digit;
            C_ARITH:   take = flags.arith;
            C_DIV:     take = flags.div;
            C_DIVBUSY: take = flags.div_busy;
            C_OUTFREE: take = flags.out_free;
            default:   take = 1'b1;
        endcase
        upc_next = take ? ctl.target : (upc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[hw/rtl/rpn_stack_evaluator.sv]
// Top level of the RPN stack evaluator: datapath, stack RAM, divider, sequencer.
// Depends on rse_pkg, rse_ram, rse_div and rse_seq.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  mode, token
//   out      source     out_valid/out_stall value, status, done_res
//
// One request at a time: a token is taken only in the wait word, then decoded and handled
// as finish, ignore, digit, illegal, or pop, load, ALU or divide, push; each ends in emit.
// Each step is one microcode word; the output register holds a result while the
// next request is taken. A stalled output holds the sequencer only when a second result is ready.
// Reset empties the stack and clears the abort flag; stack contents are not cleared.
module rpn_stack_evaluator
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [TOK_W-1:0]         token,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] value,
    output logic [ST_W-1:0]          status,
    output logic                     done_res
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    ctl_t   ctl;
    flags_t flags;

    logic              mode_reg, mode_next;
    logic [TOK_W-1:0]  tok_reg, tok_next;
    logic              aborted_reg, aborted_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] lhs_reg, lhs_next;
    logic [DATA_W-1:0] rhs_reg, rhs_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              lhs_ok_reg, lhs_ok_next;
    logic              under_reg, under_next;
    logic              dz_reg, dz_next;
    logic [DATA_W-1:0] rv_reg, rv_next;
    logic [ST_W-1:0]   rs_reg, rs_next;
    logic              rd_reg, rd_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic              out_done_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [LVL_W-1:0]  lvl_m2;
    logic              full;
    logic              out_free;
    logic              is_digit;
    logic              is_div;
    logic [TOK_W-1:0]  tok_digit;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] alu_out;
    logic              div_busy;
    logic [DATA_W-1:0] div_q;

    assign lvl_m2    = level_reg - LVL_W'(2);
    assign full      = (level_reg >= LVL_W'(STACK_DEPTH));
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_digit  = (tok_reg >= CH_ZERO) && (tok_reg <= CH_NINE);
    assign is_div    = (tok_reg == CH_SLASH);
    assign tok_digit = tok_reg - CH_ZERO;
    assign prod      = lhs_reg * rhs_reg;
    assign in_stall  = (ctl.act != A_ACCEPT);

    always_comb
    begin
        flags.noreq    = !in_valid;
        flags.finish   = mode_reg;
        flags.aborted  = aborted_reg;
        flags.digit    = is_digit;
        flags.arith    = (tok_reg == CH_PLUS) || (tok_reg == CH_MINUS)
                         || (tok_reg == CH_STAR) || is_div;
        flags.div      = is_div;
        flags.div_busy = div_busy;
        flags.out_free = out_free;
    end

    always_comb
    begin
        unique case (tok_reg)
            CH_PLUS:  alu_out = lhs_reg + rhs_reg;
            CH_MINUS: alu_out = lhs_reg - rhs_reg;
            CH_STAR:  alu_out = prod;
            default:  alu_out = lhs_reg + rhs_reg;
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        tok_next       = tok_reg;
        aborted_next   = aborted_reg;
        level_next     = level_reg;
        top_next       = top_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        res_next       = res_reg;
        lhs_ok_next    = lhs_ok_reg;
        under_next     = under_reg;
        dz_next        = dz_reg;
        rv_next        = rv_reg;
        rs_next        = rs_reg;
        rd_next        = rd_reg;
        ram_we         = 1'b0;
        ram_waddr      = level_reg[ADDR_W-1:0];
        ram_wdata      = res_reg;
        ram_raddr      = lvl_m2[ADDR_W-1:0];
        unique case (ctl.act)
            A_ACCEPT:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    tok_next  = token;
                end
            end
            A_ILLEGAL:
            begin
                aborted_next = 1'b1;
                rv_next      = top_reg;
                rs_next      = ST_ILLEGAL;
                rd_next      = 1'b0;
            end
            A_FINISH:
            begin
                rv_next      = top_reg;
                if (aborted_reg)
                begin
                    rs_next = ST_ILLEGAL;
                end
                else if (level_reg == '0)
                begin
                    rs_next = ST_UNDER;
                end
                else
                begin
                    rs_next = ST_OK;
                end
                rd_next      = 1'b1;
                level_next   = '0;
                top_next     = '0;
                aborted_next = 1'b0;
            end
            A_IGNORE:
            begin
                rv_next = top_reg;
                rs_next = ST_IGNORED;
                rd_next = 1'b0;
            end
            A_DIGIT:
            begin
                rd_next = 1'b0;
                if (full)
                begin
                    rv_next = top_reg;
                    rs_next = ST_OVER;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {{(DATA_W-TOK_W){1'b0}}, tok_digit};
                    level_next = level_reg + LVL_W'(1);
                    top_next   = ram_wdata;
                    rv_next    = ram_wdata;
                    rs_next    = ST_OK;
                end
            end
            A_POP:
            begin
                rhs_next    = (level_reg != '0) ? top_reg : '0;
                lhs_ok_next = (level_reg >= LVL_W'(2));
                under_next  = (level_reg < LVL_W'(2));
                level_next  = (level_reg >= LVL_W'(2)) ? lvl_m2 : '0;
            end
            A_LOAD:
            begin
                lhs_next = lhs_ok_reg ? ram_rdata : '0;
                dz_next  = (rhs_reg == '0);
            end
            A_ALU:
            begin
                res_next = alu_out;
            end
            A_DIVTAKE:
            begin
                res_next = dz_reg ? '0 : div_q;
            end
            A_PUSH:
            begin
                rd_next = 1'b0;
                rs_next = ST_OK;
                if (full)
                begin
                    rs_next = ST_OVER;
                    rv_next = top_reg;
                end
                else
                begin
                    ram_we     = 1'b1;
                    level_next = level_reg + LVL_W'(1);
                    top_next   = res_reg;
                    rv_next    = res_reg;
                end
                if (is_div && dz_reg)
                begin
                    rs_next = ST_DIVZERO;
                end
                if (under_reg)
                begin
                    rs_next = ST_UNDER;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((ctl.act == A_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aborted_reg   <= 1'b0;
            level_reg     <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            aborted_reg   <= aborted_next;
            level_reg     <= level_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        tok_reg    <= tok_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        res_reg    <= res_next;
        lhs_ok_reg <= lhs_ok_next;
        under_reg  <= under_next;
        dz_reg     <= dz_next;
        rv_reg     <= rv_next;
        rs_reg     <= rs_next;
        rd_reg     <= rd_next;
        if ((ctl.act == A_EMIT) && out_free)
        begin
            out_value_reg  <= rv_reg;
            out_status_reg <= rs_reg;
            out_done_reg   <= rd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;
    assign done_res  = out_done_reg;

    rse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.act == A_DIVGO),
        .dividend (lhs_reg),
        .divisor  (rhs_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    rse_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctl.act == A_ACCEPT) && (level_reg == '0)) |-> (top_reg == '0))
        else $error("empty stack with nonzero top");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken before first finished");

    a_finish_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |->
        ((status == ST_OK) || (status == ST_ILLEGAL) || (status == ST_UNDER)))
        else $error("bad status on finish result");

endmodule
